// ===== design/r2fft_pkg.sv =====
// Shared constants, types and the twiddle table of the radix-2 FFT block.
package r2fft_pkg;

    localparam int MAX_LOG2_SIZE = 10;
    localparam int SAMPLE_BITS   = 16;
    localparam int TWIDDLE_BITS  = 16;
    localparam int STORE_BITS    = SAMPLE_BITS + MAX_LOG2_SIZE + 1;
    localparam int FRAC_BITS     = TWIDDLE_BITS - 1;
    localparam int ADDR_W        = MAX_LOG2_SIZE;
    localparam int MAX_POINTS    = 1 << MAX_LOG2_SIZE;
    localparam int ROM_DEPTH     = MAX_POINTS >> 1;
    localparam int ROM_AW        = MAX_LOG2_SIZE - 1;
    localparam int LOG2_W        = 4;
    localparam int SQ_W          = 2 * STORE_BITS - 1;
    localparam int RAD_W         = 2 * STORE_BITS;
    localparam int MAG_W         = STORE_BITS - 1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic RES_DONE = 1'b0;
    localparam logic RES_BIN  = 1'b1;

    typedef enum logic [1:0] {
        WSEL_SAMPLE,
        WSEL_BF_A,
        WSEL_BF_B
    } r2fft_wsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BF_READ,
        ST_BF_MUL,
        ST_BF_ROUND,
        ST_BF_WRA,
        ST_BF_WRB,
        ST_RD_SQ,
        ST_RD_START,
        ST_RD_ROOT,
        ST_DONE
    } r2fft_state_t;

    typedef struct packed {
        logic              mem_rd;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ROM_AW-1:0] tw_idx;
        logic              tw_bypass;
        logic              mem_wr;
        r2fft_wsel_t       wsel;
        logic [ADDR_W-1:0] waddr;
        logic              mul_en;
        logic              rnd_en;
        logic              idx_load;
        logic              sq_en;
        logic              root_start;
        logic              out_load;
        logic              out_kind;
    } r2fft_cmd_t;

    typedef struct packed {
        logic out_free;
        logic root_busy;
    } r2fft_stat_t;

    typedef logic [ROM_DEPTH-1:0][2*TWIDDLE_BITS-1:0] r2fft_rom_t;

    localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
    localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // cos in the upper half, sin in the lower half, Q62
    function automatic logic [127:0] q62_cos_sin(input logic [63:0] x);
        logic [63:0] x2, tc, ts, sc, ss;
        x2 = q62_mul(x, x);
        tc = Q62_ONE;
        ts = x;
        sc = Q62_ONE;
        ss = x;
        for (int n = 1; n <= 15; n++) begin
            tc = q62_mul(tc, x2) / 64'((2 * n - 1) * (2 * n));
            ts = q62_mul(ts, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sc = sc - tc;
                ss = ss - ts;
            end else begin
                sc = sc + tc;
                ss = ss + ts;
            end
        end
        if (sc[63]) sc = 64'd0;
        if (ss[63]) ss = 64'd0;
        return {sc, ss};
    endfunction

    function automatic logic [TWIDDLE_BITS-1:0] q62_to_twiddle(input logic [63:0] v);
        logic [63:0] r, lim;
        r   = (v + (64'd1 << (62 - FRAC_BITS - 1))) >> (62 - FRAC_BITS);
        lim = (64'd1 << FRAC_BITS) - 64'd1;
        if (r > lim) r = lim;
        return r[TWIDDLE_BITS-1:0];
    endfunction

    // each entry is {cos, sin}, both signed Q1.15
    function automatic r2fft_rom_t build_twiddle_rom();
        r2fft_rom_t rom;
        logic [63:0] a4, r, x;
        logic [127:0] cs;
        logic second;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            a4 = 64'(4 * i);
            second = a4 > 64'(MAX_POINTS);
            r = second ? a4 - 64'(MAX_POINTS) : a4;
            x = (Q62_HALF_PI >> MAX_LOG2_SIZE) * r
                + (((Q62_HALF_PI & 64'(MAX_POINTS - 1)) * r) >> MAX_LOG2_SIZE);
            cs = q62_cos_sin(x);
            if (second) begin
                rom[i] = {-q62_to_twiddle(cs[63:0]), q62_to_twiddle(cs[127:64])};
            end else begin
                rom[i] = {q62_to_twiddle(cs[127:64]), q62_to_twiddle(cs[63:0])};
            end
        end
        return rom;
    endfunction

    localparam r2fft_rom_t TWIDDLE_ROM = build_twiddle_rom();

endpackage

// ===== design/r2fft_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module r2fft_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [r2fft_pkg::RAD_W-1:0]     radicand,
    output logic                            busy,
    output logic [r2fft_pkg::STORE_BITS-1:0] root
);

    logic                         busy_reg;
    logic [r2fft_pkg::RAD_W-1:0]  v_reg;
    logic [r2fft_pkg::RAD_W-1:0]  r_reg;
    logic [r2fft_pkg::RAD_W-1:0]  bit_reg;
    logic [r2fft_pkg::RAD_W-1:0]  trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && bit_reg[0]) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= r2fft_pkg::RAD_W'(1) << (r2fft_pkg::RAD_W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[r2fft_pkg::STORE_BITS-1:0];

endmodule

// ===== design/r2fft_dp.sv =====
// Datapath: sample store, butterfly arithmetic, magnitude and result register.
module r2fft_dp (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  r2fft_pkg::r2fft_cmd_t                   cmd,
    output r2fft_pkg::r2fft_stat_t                  stat,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_real,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_imag,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_result_kind,
    output logic [r2fft_pkg::ADDR_W-1:0]            m_bin_index,
    output logic signed [r2fft_pkg::STORE_BITS-1:0] m_bin_real,
    output logic signed [r2fft_pkg::STORE_BITS-1:0] m_bin_imag,
    output logic [r2fft_pkg::MAG_W-1:0]             m_bin_magnitude
);

    localparam int SW = r2fft_pkg::STORE_BITS;
    localparam int TW = r2fft_pkg::TWIDDLE_BITS;
    localparam int PW = TW + SW;         // single product
    localparam int TPW = TW + SW + 2;    // product of the two sums
    localparam int DW = TPW + 1;         // difference before rounding
    localparam int RW = DW - r2fft_pkg::FRAC_BITS;
    localparam int YW = RW + 1;

    function automatic logic signed [SW-1:0] sat_store(input logic signed [YW-1:0] v);
        logic signed [YW-1:0] hi, lo;
        hi = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
        lo = -hi - YW'(1);
        if (v > hi) return hi[SW-1:0];
        if (v < lo) return lo[SW-1:0];
        return v[SW-1:0];
    endfunction

    logic [2*SW-1:0] mem [r2fft_pkg::MAX_POINTS];
    logic [2*SW-1:0] rda_reg, rdb_reg, yb_reg, wdata;
    logic [2*TW-1:0] tw_reg;
    logic            bypass_reg;

    logic signed [SW-1:0]  ar, ai, xr, xi, ya_r, ya_i, yb_r, yb_i;
    logic signed [TW-1:0]  wr, wi;
    logic signed [TW:0]    wsum;
    logic signed [SW:0]    xsum;
    logic signed [PW-1:0]  p_reg, q_reg;
    logic signed [TPW-1:0] t_reg;
    logic signed [DW-1:0]  d_re, d_im;
    logic signed [RW-1:0]  tr_reg, ti_reg, tr_next, ti_next;

    logic [SW*2-2:0]       sq_re_reg, sq_im_reg;
    logic signed [2*SW-1:0] sq_re_full, sq_im_full;
    logic [r2fft_pkg::RAD_W-1:0] radicand;
    logic                  root_busy;
    logic [SW-1:0]         root;
    logic [r2fft_pkg::ADDR_W-1:0] idx_reg;

    logic                  m_valid_reg;
    logic                  kind_reg;
    logic [r2fft_pkg::ADDR_W-1:0] bin_index_reg;
    logic signed [SW-1:0]  bin_real_reg, bin_imag_reg;
    logic [r2fft_pkg::MAG_W-1:0] mag_reg;

    assign ar = $signed(rda_reg[2*SW-1:SW]);
    assign ai = $signed(rda_reg[SW-1:0]);
    assign xr = $signed(rdb_reg[2*SW-1:SW]);
    assign xi = $signed(rdb_reg[SW-1:0]);
    assign wr = $signed(tw_reg[2*TW-1:TW]);
    assign wi = -$signed(tw_reg[TW-1:0]);
    assign wsum = {wr[TW-1], wr} + {wi[TW-1], wi};
    assign xsum = {xr[SW-1], xr} + {xi[SW-1], xi};

    // store write port: sample loads and both butterfly outputs
    always_comb begin
        unique case (cmd.wsel)
            r2fft_pkg::WSEL_SAMPLE: wdata = {SW'(sample_real), SW'(sample_imag)};
            r2fft_pkg::WSEL_BF_A:   wdata = {ya_r, ya_i};
            r2fft_pkg::WSEL_BF_B:   wdata = yb_reg;
            default:                wdata = yb_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[cmd.waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rda_reg    <= mem[cmd.addr_a];
            rdb_reg    <= mem[cmd.addr_b];
            tw_reg     <= r2fft_pkg::TWIDDLE_ROM[cmd.tw_idx];
            bypass_reg <= cmd.tw_bypass;
        end
    end

    // three-multiply complex product
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            p_reg <= PW'(wr) * PW'(xr);
            q_reg <= PW'(wi) * PW'(xi);
            t_reg <= TPW'(wsum) * TPW'(xsum);
        end
    end

    assign d_re = DW'(p_reg) - DW'(q_reg);
    assign d_im = DW'(t_reg) - DW'(p_reg) - DW'(q_reg);

    always_comb begin
        logic signed [DW-1:0] rr, ri;
        rr = (d_re + DW'(1 << (r2fft_pkg::FRAC_BITS - 1))) >>> r2fft_pkg::FRAC_BITS;
        ri = (d_im + DW'(1 << (r2fft_pkg::FRAC_BITS - 1))) >>> r2fft_pkg::FRAC_BITS;
        if (bypass_reg) begin
            tr_next = RW'(xr);
            ti_next = RW'(xi);
        end else begin
            tr_next = rr[RW-1:0];
            ti_next = ri[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rnd_en) begin
            tr_reg <= tr_next;
            ti_reg <= ti_next;
        end
    end

    assign ya_r = sat_store(YW'(ar) + YW'(tr_reg));
    assign ya_i = sat_store(YW'(ai) + YW'(ti_reg));
    assign yb_r = sat_store(YW'(ar) - YW'(tr_reg));
    assign yb_i = sat_store(YW'(ai) - YW'(ti_reg));

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr && cmd.wsel == r2fft_pkg::WSEL_BF_A) begin
            yb_reg <= {yb_r, yb_i};
        end
    end

    // magnitude of a read bin
    assign sq_re_full = ar * ar;
    assign sq_im_full = ai * ai;

    always_ff @(posedge aclk) begin
        if (cmd.idx_load) begin
            idx_reg <= cmd.addr_a;
        end
        if (cmd.sq_en) begin
            sq_re_reg <= sq_re_full[2*SW-2:0];
            sq_im_reg <= sq_im_full[2*SW-2:0];
        end
    end

    assign radicand = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};

    r2fft_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (radicand),
        .busy     (root_busy),
        .root     (root)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_reg <= cmd.out_kind;
            if (cmd.out_kind == r2fft_pkg::RES_BIN) begin
                bin_index_reg <= idx_reg;
                bin_real_reg  <= ar;
                bin_imag_reg  <= ai;
                mag_reg       <= root[SW-1] ? '1 : root[r2fft_pkg::MAG_W-1:0];
            end else begin
                bin_index_reg <= '0;
                bin_real_reg  <= '0;
                bin_imag_reg  <= '0;
                mag_reg       <= '0;
            end
        end
    end

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.root_busy = root_busy;

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_bin_index     = bin_index_reg;
    assign m_bin_real      = bin_real_reg;
    assign m_bin_imag      = bin_imag_reg;
    assign m_bin_magnitude = mag_reg;

endmodule

// ===== design/r2fft_ctrl.sv =====
// Controller: command decode, size register and butterfly sequencing.
module r2fft_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [r2fft_pkg::ADDR_W-1:0]      s_point_index,
    input  logic                              cfg_wr_en,
    input  logic [r2fft_pkg::LOG2_W-1:0]      cfg_wr_data,
    input  r2fft_pkg::r2fft_stat_t            stat,
    output r2fft_pkg::r2fft_cmd_t             cmd
);

    localparam int AW = r2fft_pkg::ADDR_W;
    localparam int LW = r2fft_pkg::LOG2_W;

    r2fft_pkg::r2fft_state_t state_reg, state_next;
    logic [LW-1:0]   log2_reg, log2_next;
    logic [LW-1:0]   stage_reg, stage_next;
    logic [AW-2:0]   bf_reg, bf_next;
    logic            tv_reg, tv_next;
    logic            kind_reg, kind_next;

    logic [AW-1:0]   n_mask, idx_m, rev_full, rev, half_mask, bf_ext, j_idx;
    logic [AW-1:0]   addr_a_bf, addr_b_bf, tw_full;
    logic [AW-2:0]   bf_last_val;
    logic            in_bf;

    assign n_mask      = AW'(((AW + 1)'(1) << log2_reg) - (AW + 1)'(1));
    assign idx_m       = s_point_index & n_mask;
    assign bf_last_val = (AW - 1)'((AW'(1) << (log2_reg - LW'(1))) - AW'(1));

    always_comb begin
        for (int i = 0; i < AW; i++) begin
            rev_full[i] = idx_m[AW-1-i];
        end
    end
    assign rev = rev_full >> (LW'(r2fft_pkg::MAX_LOG2_SIZE) - log2_reg);

    // butterfly addresses from stage and butterfly count
    assign half_mask = (AW'(1) << (stage_reg - LW'(1))) - AW'(1);
    assign bf_ext    = {1'b0, bf_reg};
    assign j_idx     = bf_ext & half_mask;
    assign addr_a_bf = ((bf_ext & ~half_mask) << 1) | j_idx;
    assign addr_b_bf = addr_a_bf | (half_mask + AW'(1));
    assign tw_full   = j_idx << (LW'(r2fft_pkg::MAX_LOG2_SIZE) - stage_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= r2fft_pkg::ST_IDLE;
            log2_reg  <= LW'(r2fft_pkg::MAX_LOG2_SIZE);
            stage_reg <= LW'(1);
            bf_reg    <= '0;
            tv_reg    <= 1'b0;
            kind_reg  <= r2fft_pkg::RES_DONE;
        end else begin
            state_reg <= state_next;
            log2_reg  <= log2_next;
            stage_reg <= stage_next;
            bf_reg    <= bf_next;
            tv_reg    <= tv_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        log2_next  = log2_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        tv_next    = tv_reg;
        kind_next  = kind_reg;
        s_ready    = 1'b0;

        cmd            = '0;
        cmd.wsel       = r2fft_pkg::WSEL_SAMPLE;
        cmd.addr_a     = addr_a_bf;
        cmd.addr_b     = addr_b_bf;
        cmd.tw_idx     = tw_full[AW-2:0];
        cmd.tw_bypass  = (j_idx == '0);
        cmd.waddr      = addr_a_bf;
        cmd.out_kind   = kind_reg;

        // size register: clamp into the supported range, drop a finished transform
        if (cfg_wr_en) begin
            priority if (cfg_wr_data == '0) begin
                log2_next = LW'(1);
            end else if (cfg_wr_data > LW'(r2fft_pkg::MAX_LOG2_SIZE)) begin
                log2_next = LW'(r2fft_pkg::MAX_LOG2_SIZE);
            end else begin
                log2_next = cfg_wr_data;
            end
            tv_next = 1'b0;
        end

        unique case (state_reg)
            r2fft_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_command)
                        r2fft_pkg::CMD_WRITE: begin
                            cmd.mem_wr = 1'b1;
                            cmd.wsel   = r2fft_pkg::WSEL_SAMPLE;
                            cmd.waddr  = rev;
                            tv_next    = 1'b0;
                        end
                        r2fft_pkg::CMD_RUN: begin
                            kind_next = r2fft_pkg::RES_DONE;
                            if (tv_reg) begin
                                state_next = r2fft_pkg::ST_DONE;
                            end else begin
                                stage_next = LW'(1);
                                bf_next    = '0;
                                state_next = r2fft_pkg::ST_BF_READ;
                            end
                        end
                        r2fft_pkg::CMD_READ: begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_a   = idx_m;
                            cmd.idx_load = 1'b1;
                            kind_next    = r2fft_pkg::RES_BIN;
                            state_next   = r2fft_pkg::ST_RD_SQ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            r2fft_pkg::ST_BF_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = r2fft_pkg::ST_BF_MUL;
            end
            r2fft_pkg::ST_BF_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = r2fft_pkg::ST_BF_ROUND;
            end
            r2fft_pkg::ST_BF_ROUND: begin
                cmd.rnd_en = 1'b1;
                state_next = r2fft_pkg::ST_BF_WRA;
            end
            r2fft_pkg::ST_BF_WRA: begin
                cmd.mem_wr = 1'b1;
                cmd.wsel   = r2fft_pkg::WSEL_BF_A;
                cmd.waddr  = addr_a_bf;
                state_next = r2fft_pkg::ST_BF_WRB;
            end
            r2fft_pkg::ST_BF_WRB: begin
                cmd.mem_wr = 1'b1;
                cmd.wsel   = r2fft_pkg::WSEL_BF_B;
                cmd.waddr  = addr_b_bf;
                if (bf_reg == bf_last_val) begin
                    bf_next = '0;
                    if (stage_reg == log2_reg) begin
                        tv_next    = 1'b1;
                        state_next = r2fft_pkg::ST_DONE;
                    end else begin
                        stage_next = stage_reg + LW'(1);
                        state_next = r2fft_pkg::ST_BF_READ;
                    end
                end else begin
                    bf_next    = bf_reg + (AW - 1)'(1);
                    state_next = r2fft_pkg::ST_BF_READ;
                end
            end
            r2fft_pkg::ST_RD_SQ: begin
                cmd.sq_en  = 1'b1;
                state_next = r2fft_pkg::ST_RD_START;
            end
            r2fft_pkg::ST_RD_START: begin
                cmd.root_start = 1'b1;
                state_next     = r2fft_pkg::ST_RD_ROOT;
            end
            r2fft_pkg::ST_RD_ROOT: begin
                if (!stat.root_busy) begin
                    state_next = r2fft_pkg::ST_DONE;
                end
            end
            r2fft_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = r2fft_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign in_bf = (state_reg == r2fft_pkg::ST_BF_READ) || (state_reg == r2fft_pkg::ST_BF_MUL)
                || (state_reg == r2fft_pkg::ST_BF_ROUND) || (state_reg == r2fft_pkg::ST_BF_WRA)
                || (state_reg == r2fft_pkg::ST_BF_WRB);

    a_bf_pair_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        in_bf |-> (addr_a_bf != addr_b_bf))
        else $error("butterfly pair addresses coincide");

    a_stage_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_bf |-> (stage_reg >= LW'(1) && stage_reg <= log2_reg))
        else $error("stage count outside transform length");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten while occupied");

    a_root_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_start |-> !stat.root_busy)
        else $error("square root started while busy");

endmodule

// ===== design/radix2_fft_with_magnitude_top.sv =====
// Top level of the radix-2 decimation-in-time FFT block with bin magnitude.
//
// In-place radix-2 DIT FFT over N = 2^fft_log2_size points (2..1024), set through
// cfg_wr_en/cfg_wr_data (values clamp into 1..10; a write drops a finished
// transform). Command 0 loads a 16-bit complex sample at the bit-reversed address
// of its index and produces no item. Command 1 runs log2(N) stages of
// butterflies with Q1.15 twiddles and a three-multiply complex product, then
// returns a done item (kind 0, other fields zero); a second run without a new
// sample or size write returns done without transforming again. Command 2
// returns one bin (kind 1) with 27-bit real and imaginary parts and the floor of
// its magnitude, saturated to 2^26-1. A read waits on the bit-serial square root
// (27 steps); a run is paced by the unpipelined butterfly, which does one store
// read, one multiply, one rounding step and two writes through the single write
// port of the sample store. Items are taken only while no command is in
// progress; a finished item waits in the output register while the next load is
// accepted.
// The store has no reset: read only entries that were loaded.
module radix2_fft_with_magnitude_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_command,
    input  logic [r2fft_pkg::ADDR_W-1:0]            s_point_index,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] s_sample_real,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] s_sample_imag,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_result_kind,
    output logic [r2fft_pkg::ADDR_W-1:0]            m_bin_index,
    output logic signed [r2fft_pkg::STORE_BITS-1:0] m_bin_real,
    output logic signed [r2fft_pkg::STORE_BITS-1:0] m_bin_imag,
    output logic [r2fft_pkg::MAG_W-1:0]             m_bin_magnitude,
    input  logic                                    cfg_wr_en,
    input  logic [r2fft_pkg::LOG2_W-1:0]            cfg_wr_data
);

    // command and status between sequencer and datapath
    r2fft_pkg::r2fft_cmd_t  cmd;
    r2fft_pkg::r2fft_stat_t stat;

    r2fft_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_point_index (s_point_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .stat          (stat),
        .cmd           (cmd)
    );

    r2fft_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .sample_real     (s_sample_real),
        .sample_imag     (s_sample_imag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_bin_index     (m_bin_index),
        .m_bin_real      (m_bin_real),
        .m_bin_imag      (m_bin_imag),
        .m_bin_magnitude (m_bin_magnitude)
    );

endmodule

// ===== tb/sv/radix2_fft_with_magnitude_top_test.sv =====
// Self-checking testbench of the radix-2 FFT block with bin magnitude.
`timescale 1ns / 1ps

module radix2_fft_with_magnitude_top_test;

    localparam int AW = r2fft_pkg::ADDR_W;
    localparam int SB = r2fft_pkg::STORE_BITS;
    localparam int MW = r2fft_pkg::MAG_W;
    localparam int TB = r2fft_pkg::TWIDDLE_BITS;
    localparam int FB = r2fft_pkg::FRAC_BITS;
    localparam int ML = r2fft_pkg::MAX_LOG2_SIZE;
    localparam int MP = r2fft_pkg::MAX_POINTS;

    // command code that the block drops without a result
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic                 kind;
        logic [AW-1:0]        index;
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic [MW-1:0]        mag;
    } bin_result_t;

    typedef enum logic { ROW_ITEM, ROW_SIZE } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [1:0]    cmd;
        logic [AW-1:0] index;
        logic [15:0]   sre;
        logic [15:0]   sim;
        logic [3:0]    size_code;
        bit            typed;
        bin_result_t   result;
    } stim_row_t;

    logic                                     aclk;
    logic                                     aresetn;
    logic                                     s_valid;
    logic                                     s_ready;
    logic [1:0]                               s_command;
    logic [AW-1:0]                            s_point_index;
    logic signed [r2fft_pkg::SAMPLE_BITS-1:0] s_sample_real;
    logic signed [r2fft_pkg::SAMPLE_BITS-1:0] s_sample_imag;
    logic                                     m_valid;
    logic                                     m_ready;
    logic                                     m_result_kind;
    logic [AW-1:0]                            m_bin_index;
    logic signed [SB-1:0]                     m_bin_real;
    logic signed [SB-1:0]                     m_bin_imag;
    logic [MW-1:0]                            m_bin_magnitude;
    logic                                     cfg_wr_en;
    logic [r2fft_pkg::LOG2_W-1:0]             cfg_wr_data;

    // predictor state: sample store, written flags, done flag, size
    longint      spec_re [MP];
    longint      spec_im [MP];
    bit          loaded  [MP];
    bit          spectrum_ready;
    int          log2_n;

    bin_result_t pending_results[$];
    stim_row_t   stim_rows[$];
    int          failures;
    int          idle_mode;

    radix2_fft_with_magnitude_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_point_index   (s_point_index),
        .s_sample_real   (s_sample_real),
        .s_sample_imag   (s_sample_imag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_bin_index     (m_bin_index),
        .m_bin_real      (m_bin_real),
        .m_bin_imag      (m_bin_imag),
        .m_bin_magnitude (m_bin_magnitude),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // clip a butterfly output into the 27-bit store
    function automatic longint clip_store(longint v);
        longint hi;
        hi = (longint'(1) << (SB - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (longint'(1) << i);
            if (b * b <= v) r = b;
        end
        return r;
    endfunction

    // in-place DIT butterflies over the current size, twiddles from the package table
    task automatic transform_store();
        int     n, span, half, a, b, k;
        longint xr, xi, tr, ti, wr, wi, p, q, t;
        n = 1 << log2_n;
        for (int s = 1; s <= log2_n; s++) begin
            span = 1 << s;
            half = span >> 1;
            for (int base = 0; base < n; base += span) begin
                for (int j = 0; j < half; j++) begin
                    a  = base + j;
                    b  = a + half;
                    xr = spec_re[b];
                    xi = spec_im[b];
                    if (j == 0) begin
                        tr = xr;
                        ti = xi;
                    end else begin
                        k  = (j << (ML - s)) & (r2fft_pkg::ROM_DEPTH - 1);
                        wr = longint'($signed(r2fft_pkg::TWIDDLE_ROM[k][2*TB-1:TB]));
                        wi = -longint'($signed(r2fft_pkg::TWIDDLE_ROM[k][TB-1:0]));
                        p  = wr * xr;
                        q  = wi * xi;
                        t  = (wr + wi) * (xr + xi);
                        // round to nearest, ties toward plus infinity
                        tr = (p - q + (longint'(1) << (FB - 1))) >>> FB;
                        ti = (t - p - q + (longint'(1) << (FB - 1))) >>> FB;
                    end
                    spec_re[b] = clip_store(spec_re[a] - tr);
                    spec_im[b] = clip_store(spec_im[a] - ti);
                    spec_re[a] = clip_store(spec_re[a] + tr);
                    spec_im[a] = clip_store(spec_im[a] + ti);
                end
            end
        end
    endtask

    // advance the predictor by one accepted item
    task automatic predict_fft(input logic [1:0] cmd, input logic [AW-1:0] index,
                               input logic [15:0] sre, input logic [15:0] sim,
                               output bit has_result, output bin_result_t r);
        int              idx, rev;
        longint unsigned ar, ai, mag;
        idx = int'(index) & ((1 << log2_n) - 1);
        has_result = 1'b0;
        r = '{r2fft_pkg::RES_DONE, '0, '0, '0, '0};
        case (cmd)
            r2fft_pkg::CMD_WRITE: begin
                rev = 0;
                for (int b = 0; b < log2_n; b++) rev |= ((idx >> b) & 1) << (log2_n - 1 - b);
                spec_re[rev]   = longint'($signed(sre));
                spec_im[rev]   = longint'($signed(sim));
                loaded[rev]    = 1'b1;
                spectrum_ready = 1'b0;
            end
            r2fft_pkg::CMD_RUN: begin
                if (!spectrum_ready) transform_store();
                spectrum_ready = 1'b1;
                has_result = 1'b1;
            end
            r2fft_pkg::CMD_READ: begin
                ar  = longint'(spec_re[idx] < 0 ? -spec_re[idx] : spec_re[idx]);
                ai  = longint'(spec_im[idx] < 0 ? -spec_im[idx] : spec_im[idx]);
                mag = floor_sqrt(ar * ar + ai * ai);
                if (mag > (64'd1 << MW) - 1) mag = (64'd1 << MW) - 1;
                has_result = 1'b1;
                r = '{r2fft_pkg::RES_BIN, AW'(idx), SB'(spec_re[idx]),
                      SB'(spec_im[idx]), MW'(mag)};
            end
            default: ;
        endcase
    endtask

    // drive one item, hold it until accepted, then predict it
    task automatic send_item(input logic [1:0] cmd, input logic [AW-1:0] index,
                             input logic [15:0] sre, input logic [15:0] sim,
                             input bit typed, input bin_result_t typed_result);
        bit          has_result;
        bin_result_t r;
        int          gap_pct;
        gap_pct = (idle_mode == 0) ? 6 : (idle_mode == 1) ? 57 : 0;
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_point_index <= index;
        s_sample_real <= sre;
        s_sample_imag <= sim;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_fft(cmd, index, sre, sim, has_result, r);
        if (has_result) begin
            if (typed) pending_results = {pending_results, typed_result};
            else pending_results = {pending_results, r};
        end
    endtask

    // drop valid, drain the block, then write the size register
    task automatic write_size(input logic [3:0] code);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        log2_n = (code < 1) ? 1 : (code > ML) ? ML : int'(code);
        spectrum_ready = 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [1:0] cmd,
                           input logic [AW-1:0] index, input logic [15:0] sre,
                           input logic [15:0] sim, input bit typed, input bin_result_t r);
        stim_row_t row;
        row = '{kind, cmd, index, sre, sim, index[3:0], typed, r};
        stim_rows = {stim_rows, row};
    endtask

    // load every point of the current size, then a random mix of commands
    task automatic random_phase(input logic [3:0] code, input int count);
        int          n, pick, idx;
        logic [15:0] sre, sim;
        bin_result_t none;
        none = '{r2fft_pkg::RES_DONE, '0, '0, '0, '0};
        write_size(code);
        n = 1 << log2_n;
        for (int i = 0; i < n; i++) send_item(r2fft_pkg::CMD_WRITE,
                                              AW'(i) | AW'($urandom << log2_n),
                                              16'($urandom), 16'($urandom), 1'b0, none);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            idx  = $urandom_range(MP - 1);
            case ($urandom_range(3))
                0: sre = 16'h8000;
                1: sre = 16'h7FFF;
                default: sre = 16'($urandom);
            endcase
            sim = ($urandom_range(3) == 0) ? {sre[15], ~sre[14:0]} : 16'($urandom);
            if (pick < 50)
                send_item(r2fft_pkg::CMD_WRITE, AW'(idx), sre, sim, 1'b0, none);
            else if (pick < 62 && log2_n < ML)
                send_item(r2fft_pkg::CMD_RUN, AW'(idx), sre, sim, 1'b0, none);
            else if (pick < 95 && loaded[idx & (n - 1)])
                send_item(r2fft_pkg::CMD_READ, AW'(idx), sre, sim, 1'b0, none);
            else
                send_item(CMD_NONE, AW'(idx), sre, sim, 1'b0, none);
        end
    endtask

    // receiver stall pattern follows the current idle mode
    always @(negedge aclk) begin
        if (idle_mode == 0) begin
            m_ready <= ($urandom_range(99) >= 57);
        end else if (idle_mode == 1) begin
            m_ready <= ($urandom_range(99) >= 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item kind %0d", m_result_kind);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, m_result_kind);
                    failures++;
                end
                if (m_bin_index !== want.index) begin
                    $error("bin_index: expected %0d, got %0d", want.index, m_bin_index);
                    failures++;
                end
                if (m_bin_real !== want.re) begin
                    $error("bin_real: expected %0d, got %0d", want.re, m_bin_real);
                    failures++;
                end
                if (m_bin_imag !== want.im) begin
                    $error("bin_imag: expected %0d, got %0d", want.im, m_bin_imag);
                    failures++;
                end
                if (m_bin_magnitude !== want.mag) begin
                    $error("bin_magnitude: expected %0d, got %0d", want.mag, m_bin_magnitude);
                    failures++;
                end
            end
        end
    end

    initial begin
        bin_result_t none, done_item;
        logic [3:0]  phase_codes[9];
        none      = '{r2fft_pkg::RES_DONE, '0, '0, '0, '0};
        done_item = none;
        phase_codes = '{4'd0, 4'd2, 4'd3, 4'd4, 4'd7, 4'd5, 4'd1, 4'd3, 4'd6};
        failures = 0;
        idle_mode = 0;
        s_valid = 1'b0;
        s_command = r2fft_pkg::CMD_WRITE;
        s_point_index = '0;
        s_sample_real = '0;
        s_sample_imag = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        aresetn = 1'b0;
        log2_n = ML;
        spectrum_ready = 1'b0;
        foreach (loaded[i]) begin
            loaded[i]  = 1'b0;
            spec_re[i] = 0;
            spec_im[i] = 0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows: extremes at reset size, ignored code, clamped sizes, repeated run
        add_row(ROW_ITEM, r2fft_pkg::CMD_WRITE, 10'd0, 16'h8000, 16'h8000, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd0, '0, '0, 1'b1,
                '{r2fft_pkg::RES_BIN, 10'd0, -27'sd32768, -27'sd32768, 26'd46340});
        add_row(ROW_ITEM, r2fft_pkg::CMD_WRITE, 10'd1023, 16'h7FFF, 16'h7FFF, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd1023, '0, '0, 1'b1,
                '{r2fft_pkg::RES_BIN, 10'd1023, 27'sd32767, 27'sd32767, 26'd46339});
        add_row(ROW_ITEM, CMD_NONE, 10'd5, 16'h1234, 16'h4321, 1'b0, none);
        add_row(ROW_SIZE, r2fft_pkg::CMD_WRITE, 10'd0, '0, '0, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_WRITE, 10'd0, 16'h7FFF, 16'h8000, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_WRITE, 10'd1, 16'h8000, 16'h7FFF, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd1, '0, '0, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_RUN, 10'd0, '0, '0, 1'b1, done_item);
        add_row(ROW_ITEM, r2fft_pkg::CMD_RUN, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1, done_item);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd0, '0, '0, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'h3FF, '0, '0, 1'b0, none);
        add_row(ROW_SIZE, r2fft_pkg::CMD_WRITE, 10'd15, '0, '0, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd0, '0, '0, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_WRITE, 10'd512, 16'd100, -16'sd100, 1'b0, none);
        add_row(ROW_ITEM, r2fft_pkg::CMD_READ, 10'd1, '0, '0, 1'b1,
                '{r2fft_pkg::RES_BIN, 10'd1, 27'sd100, -27'sd100, 26'd141});

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_SIZE)
                write_size(stim_rows[i].size_code);
            else
                send_item(stim_rows[i].cmd, stim_rows[i].index, stim_rows[i].sre,
                          stim_rows[i].sim, stim_rows[i].typed, stim_rows[i].result);
        end

        // three idle regimes, three size phases each
        foreach (phase_codes[p]) begin
            idle_mode = p / 3;
            random_phase(phase_codes[p], 35);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (60) @(posedge aclk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
